@@ hdl/rvd_pkg.sv @@
`timescale 1ns / 1ps

package rvd_pkg;

  // Major opcodes, taken from instruction bits 6 to 0.
  localparam logic [6:0] OPC_ALU_R   = 7'h33;
  localparam logic [6:0] OPC_ALU_I   = 7'h13;
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_FENCE   = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM  = 7'h73;
  localparam logic [6:0] OPC_VDOT8   = 7'h0B;
  localparam logic [6:0] OPC_TLOOKUP = 7'h2B;

  // funct7 codes.
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MD   = 7'h01;

  // funct3 codes that the decoder singles out.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_CSRRS = 3'd2;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_PRIV = 3'd0;

  // SYSTEM immediates for the two environment calls.
  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;

  // Reset values of the identity CSR numbers.
  localparam logic [11:0] WARP_ID_CSR_RST    = 12'd3104;
  localparam logic [11:0] LANE_ID_CSR_RST    = 12'd3105;
  localparam logic [11:0] WARP_COUNT_CSR_RST = 12'd3106;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WARP_ID    = 2'd0;
  localparam logic [1:0] CFG_LANE_ID    = 2'd1;
  localparam logic [1:0] CFG_WARP_COUNT = 2'd2;

  // ALU sub-operation codes.
  localparam logic [3:0] SUB_ADD  = 4'd0;
  localparam logic [3:0] SUB_SUB  = 4'd1;
  localparam logic [3:0] SUB_SLL  = 4'd2;
  localparam logic [3:0] SUB_SLT  = 4'd3;
  localparam logic [3:0] SUB_SLTU = 4'd4;
  localparam logic [3:0] SUB_XOR  = 4'd5;
  localparam logic [3:0] SUB_SRL  = 4'd6;
  localparam logic [3:0] SUB_SRA  = 4'd7;
  localparam logic [3:0] SUB_OR   = 4'd8;
  localparam logic [3:0] SUB_AND  = 4'd9;

  typedef enum logic [4:0] {
    CLS_INVALID = 5'd0,
    CLS_ALU_R   = 5'd1,
    CLS_ALU_I   = 5'd2,
    CLS_MUL     = 5'd3,
    CLS_DIV     = 5'd4,
    CLS_LUI     = 5'd5,
    CLS_AUIPC   = 5'd6,
    CLS_JAL     = 5'd7,
    CLS_JALR    = 5'd8,
    CLS_BRANCH  = 5'd9,
    CLS_LOAD    = 5'd10,
    CLS_STORE   = 5'd11,
    CLS_FENCE   = 5'd12,
    CLS_ECALL   = 5'd13,
    CLS_EBREAK  = 5'd14,
    CLS_CSR     = 5'd15,
    CLS_VDOT8   = 5'd16,
    CLS_TLOOKUP = 5'd17
  } instr_class_e;

  typedef enum logic [2:0] {
    UNIT_ALU    = 3'd0,
    UNIT_MUL    = 3'd1,
    UNIT_DIV    = 3'd2,
    UNIT_LSU    = 3'd3,
    UNIT_SYSTEM = 3'd4,
    UNIT_TABLE  = 3'd5
  } exec_unit_e;

  // The three CSR numbers that identity reads may use.
  typedef struct packed {
    logic [11:0] warp_id;
    logic [11:0] lane_id;
    logic [11:0] warp_count;
  } csr_map_t;

  // One decoded instruction.
  typedef struct packed {
    instr_class_e instr_class;
    exec_unit_e   exec_unit;
    logic [3:0]   sub_op;
    logic [4:0]   dest_reg;
    logic [4:0]   src1_reg;
    logic [4:0]   src2_reg;
    logic         writes_dest;
    logic         reads_dest;
    logic [1:0]   source_count;
    logic [31:0]  immediate;
    logic [11:0]  csr_number;
  } decode_t;

  // ALU sub-operation for a register or immediate form with base funct7.
  function automatic logic [3:0] alu_base_op(input logic [2:0] f3);
    logic [3:0] op;
    unique case (f3)
      3'd0:    op = SUB_ADD;
      3'd1:    op = SUB_SLL;
      3'd2:    op = SUB_SLT;
      3'd3:    op = SUB_SLTU;
      3'd4:    op = SUB_XOR;
      3'd5:    op = SUB_SRL;
      3'd6:    op = SUB_OR;
      default: op = SUB_AND;
    endcase
    return op;
  endfunction

endpackage

@@ hdl/rv32im_custom_instruction_decoder.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   instruction_word_i
// out      output     out_valid_o / out_stall_i decoded fields, one beat per instruction
// cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// A beat is taken into an input register, decoded by one level of logic and
// held in a result register; one beat per cycle is sustained while the output
// is not stalled. The rate is set by the input and result registers alone.
// Reset restores the three identity CSR numbers and empties both registers.
// A stall on the output backs up into the input stage; the input is stalled
// only when both registers are full and the output is stalled.

module rv32im_custom_instruction_decoder import rvd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        instruction_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         instr_class_o,
  output logic [2:0]         exec_unit_o,
  output logic [3:0]         sub_op_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic               writes_dest_o,
  output logic               reads_dest_o,
  output logic [1:0]         source_count_o,
  output logic signed [31:0] immediate_o,
  output logic [11:0]        csr_number_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [11:0]        cfg_wdata_i
);

  logic        in_valid_q, in_valid_d;
  logic [31:0] instr_q;
  logic        out_valid_q, out_valid_d;
  decode_t     res_q;
  decode_t     dec;
  csr_map_t    csr_map_q;
  logic        in_accept;
  logic        advance;

  // Identity CSR numbers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csr_map_q.warp_id    <= WARP_ID_CSR_RST;
      csr_map_q.lane_id    <= LANE_ID_CSR_RST;
      csr_map_q.warp_count <= WARP_COUNT_CSR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WARP_ID:    csr_map_q.warp_id    <= cfg_wdata_i;
        CFG_LANE_ID:    csr_map_q.lane_id    <= cfg_wdata_i;
        CFG_WARP_COUNT: csr_map_q.warp_count <= cfg_wdata_i;
        default:        csr_map_q            <= csr_map_q;
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result register is free or is being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      instr_q <= instruction_word_i;
    end
  end

  // Decode logic between the two registers.
  rvd_decode u_decode (
    .instr_i   (instr_q),
    .csr_map_i (csr_map_q),
    .dec_o     (dec)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= dec;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign instr_class_o  = res_q.instr_class;
  assign exec_unit_o    = res_q.exec_unit;
  assign sub_op_o       = res_q.sub_op;
  assign dest_reg_o     = res_q.dest_reg;
  assign src1_reg_o     = res_q.src1_reg;
  assign src2_reg_o     = res_q.src2_reg;
  assign writes_dest_o  = res_q.writes_dest;
  assign reads_dest_o   = res_q.reads_dest;
  assign source_count_o = res_q.source_count;
  assign immediate_o    = $signed(res_q.immediate);
  assign csr_number_o   = res_q.csr_number;

  // An invalid result carries no unit, operation, flags, immediate or CSR.
  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && instr_class_o == CLS_INVALID |->
      exec_unit_o == UNIT_ALU && sub_op_o == 4'd0 && !writes_dest_o &&
      source_count_o == 2'd0 && immediate_o == 32'sd0 && csr_number_o == 12'd0)
    else $error("invalid decode carries nonzero fields");

  // Only vdot8 reads its destination, and it checks three sources.
  a_reads_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reads_dest_o |->
      instr_class_o == CLS_VDOT8 && source_count_o == 2'd3)
    else $error("reads_dest outside vdot8");

  // A nonzero CSR number comes only with a CSR read of a configured address.
  a_csr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && csr_number_o != 12'd0 |->
      instr_class_o == CLS_CSR && (csr_number_o == csr_map_q.warp_id ||
      csr_number_o == csr_map_q.lane_id || csr_number_o == csr_map_q.warp_count))
    else $error("csr number without a matching csr read");

  // A beat is never taken into a full input stage that cannot drain.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !in_valid_q || advance)
    else $error("input register overwritten");

  // A blocked input stage keeps its beat.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(instr_q))
    else $error("blocked beat lost");

endmodule

@@ hdl/rvd_decode.sv @@
`timescale 1ns / 1ps

module rvd_decode import rvd_pkg::*; (
  input  logic [31:0] instr_i,
  input  csr_map_t    csr_map_i,
  output decode_t     dec_o
);

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [11:0] csr_field;
  logic [31:0] imm_i_w;
  logic [31:0] imm_s_w;
  logic [31:0] imm_b_w;
  logic [31:0] imm_j_w;
  logic [31:0] imm_u_w;
  logic [31:0] shamt_w;
  decode_t     d;

  // Field extraction and the immediate formats.
  assign op        = instr_i[6:0];
  assign f3        = instr_i[14:12];
  assign f7        = instr_i[31:25];
  assign csr_field = instr_i[31:20];
  assign imm_i_w   = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s_w   = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b_w   = {{20{instr_i[31]}}, instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
  assign imm_j_w   = {{12{instr_i[31]}}, instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
  assign imm_u_w   = {instr_i[31:12], 12'h000};
  assign shamt_w   = {27'd0, instr_i[24:20]};

  // Opcode decode; anything not recognized leaves the class invalid.
  always_comb begin
    d              = '0;
    d.instr_class  = CLS_INVALID;
    d.exec_unit    = UNIT_ALU;
    unique case (op)
      OPC_ALU_R: begin
        if (f7 == F7_MD) begin
          d.instr_class  = f3[2] ? CLS_DIV : CLS_MUL;
          d.exec_unit    = f3[2] ? UNIT_DIV : UNIT_MUL;
          d.sub_op       = {1'b0, f3};
          d.writes_dest  = 1'b1;
          d.source_count = 2'd2;
        end else if (f7 == F7_BASE) begin
          d.instr_class  = CLS_ALU_R;
          d.sub_op       = alu_base_op(f3);
          d.writes_dest  = 1'b1;
          d.source_count = 2'd2;
        end else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL)) begin
          d.instr_class  = CLS_ALU_R;
          d.sub_op       = (f3 == F3_ADD) ? SUB_SUB : SUB_SRA;
          d.writes_dest  = 1'b1;
          d.source_count = 2'd2;
        end
      end
      OPC_ALU_I: begin
        if (f3 == F3_SLL) begin
          if (f7 == F7_BASE) begin
            d.instr_class = CLS_ALU_I;
            d.sub_op      = SUB_SLL;
            d.immediate   = shamt_w;
          end
        end else if (f3 == F3_SRL) begin
          if (f7 == F7_BASE || f7 == F7_ALT) begin
            d.instr_class = CLS_ALU_I;
            d.sub_op      = (f7 == F7_ALT) ? SUB_SRA : SUB_SRL;
            d.immediate   = shamt_w;
          end
        end else begin
          d.instr_class = CLS_ALU_I;
          d.sub_op      = alu_base_op(f3);
          d.immediate   = imm_i_w;
        end
        d.writes_dest  = 1'b1;
        d.source_count = 2'd1;
      end
      OPC_LUI: begin
        d.instr_class = CLS_LUI;
        d.writes_dest = 1'b1;
        d.immediate   = imm_u_w;
      end
      OPC_AUIPC: begin
        d.instr_class = CLS_AUIPC;
        d.writes_dest = 1'b1;
        d.immediate   = imm_u_w;
      end
      OPC_JAL: begin
        d.instr_class = CLS_JAL;
        d.writes_dest = 1'b1;
        d.immediate   = imm_j_w;
      end
      OPC_JALR: begin
        if (f3 == F3_ADD) begin
          d.instr_class  = CLS_JALR;
          d.writes_dest  = 1'b1;
          d.source_count = 2'd1;
          d.immediate    = imm_i_w;
        end
      end
      OPC_BRANCH: begin
        // Codes 2 and 3 are unused; the rest pack down to 0..5.
        if (f3[2:1] != 2'b01) begin
          d.instr_class  = CLS_BRANCH;
          d.sub_op       = f3[2] ? {1'b0, f3 - 3'd2} : {1'b0, f3};
          d.source_count = 2'd2;
          d.immediate    = imm_b_w;
        end
      end
      OPC_LOAD: begin
        // Valid widths: lb, lh, lw, lbu, lhu.
        if (f3 != 3'd3 && f3 != 3'd6 && f3 != 3'd7) begin
          d.instr_class  = CLS_LOAD;
          d.exec_unit    = UNIT_LSU;
          d.sub_op       = f3[2] ? {1'b0, f3 - 3'd1} : {1'b0, f3};
          d.writes_dest  = 1'b1;
          d.source_count = 2'd1;
          d.immediate    = imm_i_w;
        end
      end
      OPC_STORE: begin
        if (f3 <= 3'd2) begin
          d.instr_class  = CLS_STORE;
          d.exec_unit    = UNIT_LSU;
          d.sub_op       = {1'b0, f3};
          d.source_count = 2'd2;
          d.immediate    = imm_s_w;
        end
      end
      OPC_FENCE: begin
        d.instr_class = CLS_FENCE;
      end
      OPC_SYSTEM: begin
        if (f3 == F3_PRIV) begin
          if (csr_field == SYS_ECALL) begin
            d.instr_class = CLS_ECALL;
            d.exec_unit   = UNIT_SYSTEM;
          end else if (csr_field == SYS_EBREAK) begin
            d.instr_class = CLS_EBREAK;
            d.exec_unit   = UNIT_SYSTEM;
          end
        end else if (f3 == F3_CSRRS && instr_i[19:15] == 5'd0) begin
          if (csr_field == csr_map_i.warp_id || csr_field == csr_map_i.lane_id ||
              csr_field == csr_map_i.warp_count) begin
            d.instr_class = CLS_CSR;
            d.writes_dest = 1'b1;
            d.csr_number  = csr_field;
          end
        end
      end
      OPC_VDOT8: begin
        if (f7 == 7'd0 && f3 == 3'd0) begin
          d.instr_class  = CLS_VDOT8;
          d.exec_unit    = UNIT_MUL;
          d.writes_dest  = 1'b1;
          d.reads_dest   = 1'b1;
          d.source_count = 2'd3;
        end
      end
      OPC_TLOOKUP: begin
        d.instr_class  = CLS_TLOOKUP;
        d.exec_unit    = UNIT_TABLE;
        d.writes_dest  = 1'b1;
        d.source_count = 2'd1;
        d.immediate    = imm_i_w;
      end
      default: begin
        d.instr_class = CLS_INVALID;
      end
    endcase

    // An invalid encoding carries nothing but the raw register fields.
    if (d.instr_class == CLS_INVALID) begin
      d = '0;
    end
    d.dest_reg = instr_i[11:7];
    d.src1_reg = instr_i[19:15];
    d.src2_reg = instr_i[24:20];
  end

  assign dec_o = d;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rvd_pkg::*;

  // Config index that maps to no register; writes to it must be ignored.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [31:0] word;
    decode_t     want;
  } pending_decode_t;

  typedef struct {
    logic [31:0] word;
    bit          fixed;
    decode_t     want;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] instruction_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [4:0]  instr_class_o;
  logic [2:0]  exec_unit_o;
  logic [3:0]  sub_op_o;
  logic [4:0]  dest_reg_o;
  logic [4:0]  src1_reg_o;
  logic [4:0]  src2_reg_o;
  logic        writes_dest_o;
  logic        reads_dest_o;
  logic [1:0]  source_count_o;
  logic signed [31:0] immediate_o;
  logic [11:0] csr_number_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [11:0] cfg_wdata_i = '0;

  // Our copy of the three identity CSR numbers.
  csr_map_t csr_ids;

  pending_decode_t pending_decodes[$];
  directed_row_t   directed_rows[$];

  bit gaps_on = 1'b1;
  int error_count = 0;
  int result_beats = 0;

  rv32im_custom_instruction_decoder uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .instruction_word_i (instruction_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .instr_class_o      (instr_class_o),
    .exec_unit_o        (exec_unit_o),
    .sub_op_o           (sub_op_o),
    .dest_reg_o         (dest_reg_o),
    .src1_reg_o         (src1_reg_o),
    .src2_reg_o         (src2_reg_o),
    .writes_dest_o      (writes_dest_o),
    .reads_dest_o       (reads_dest_o),
    .source_count_o     (source_count_o),
    .immediate_o        (immediate_o),
    .csr_number_o       (csr_number_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Safety net against a hung handshake.
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Instruction encoders for register and immediate layouts.
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  // ALU operation selected by funct3 for the base funct7 encoding.
  function automatic logic [3:0] alu_sub_for(input logic [2:0] f3);
    case (f3)
      3'd0:    return SUB_ADD;
      3'd1:    return SUB_SLL;
      3'd2:    return SUB_SLT;
      3'd3:    return SUB_SLTU;
      3'd4:    return SUB_XOR;
      3'd5:    return SUB_SRL;
      3'd6:    return SUB_OR;
      default: return SUB_AND;
    endcase
  endfunction

  // Decode of one instruction word under the given identity CSR numbers.
  function automatic decode_t predict_decode(input logic [31:0] w, input csr_map_t ids);
    decode_t     d;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] csr;
    logic [31:0] imm_i;
    f3 = w[14:12];
    f7 = w[31:25];
    csr = w[31:20];
    imm_i = {{20{w[31]}}, w[31:20]};
    d = '0;
    d.dest_reg = w[11:7];
    d.src1_reg = w[19:15];
    d.src2_reg = w[24:20];

    // Class, unit, sub-operation and immediate per major opcode.
    case (w[6:0])
      OPC_ALU_R: begin
        if (f7 == F7_MD) begin
          if (f3[2]) begin
            d.instr_class = CLS_DIV;
            d.exec_unit = UNIT_DIV;
          end else begin
            d.instr_class = CLS_MUL;
            d.exec_unit = UNIT_MUL;
          end
          d.sub_op = {1'b0, f3};
        end else if (f7 == F7_BASE) begin
          d.instr_class = CLS_ALU_R;
          d.sub_op = alu_sub_for(f3);
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          d.instr_class = CLS_ALU_R;
          d.sub_op = SUB_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SRL) begin
          d.instr_class = CLS_ALU_R;
          d.sub_op = SUB_SRA;
        end
      end
      OPC_ALU_I: begin
        if (f3 == F3_SLL) begin
          if (f7 == F7_BASE) begin
            d.instr_class = CLS_ALU_I;
            d.sub_op = SUB_SLL;
            d.immediate = {27'd0, w[24:20]};
          end
        end else if (f3 == F3_SRL) begin
          if (f7 == F7_BASE || f7 == F7_ALT) begin
            d.instr_class = CLS_ALU_I;
            d.sub_op = (f7 == F7_ALT) ? SUB_SRA : SUB_SRL;
            d.immediate = {27'd0, w[24:20]};
          end
        end else begin
          d.instr_class = CLS_ALU_I;
          d.sub_op = alu_sub_for(f3);
          d.immediate = imm_i;
        end
      end
      OPC_LUI: begin
        d.instr_class = CLS_LUI;
        d.immediate = {w[31:12], 12'd0};
      end
      OPC_AUIPC: begin
        d.instr_class = CLS_AUIPC;
        d.immediate = {w[31:12], 12'd0};
      end
      OPC_JAL: begin
        d.instr_class = CLS_JAL;
        d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_JALR: begin
        if (f3 == 3'd0) begin
          d.instr_class = CLS_JALR;
          d.immediate = imm_i;
        end
      end
      OPC_BRANCH: begin
        if (f3 != 3'd2 && f3 != 3'd3) begin
          d.instr_class = CLS_BRANCH;
          d.sub_op = f3[2] ? {1'b0, f3} - 4'd2 : {1'b0, f3};
          d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
      end
      OPC_LOAD: begin
        if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5) begin
          d.instr_class = CLS_LOAD;
          d.exec_unit = UNIT_LSU;
          d.sub_op = f3[2] ? {1'b0, f3} - 4'd1 : {1'b0, f3};
          d.immediate = imm_i;
        end
      end
      OPC_STORE: begin
        if (f3 <= 3'd2) begin
          d.instr_class = CLS_STORE;
          d.exec_unit = UNIT_LSU;
          d.sub_op = {1'b0, f3};
          d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        end
      end
      OPC_FENCE: d.instr_class = CLS_FENCE;
      OPC_SYSTEM: begin
        if (f3 == F3_PRIV && csr == SYS_ECALL) begin
          d.instr_class = CLS_ECALL;
          d.exec_unit = UNIT_SYSTEM;
        end else if (f3 == F3_PRIV && csr == SYS_EBREAK) begin
          d.instr_class = CLS_EBREAK;
          d.exec_unit = UNIT_SYSTEM;
        end else if (f3 == F3_CSRRS && w[19:15] == 5'd0 &&
                     (csr == ids.warp_id || csr == ids.lane_id || csr == ids.warp_count)) begin
          d.instr_class = CLS_CSR;
          d.csr_number = csr;
        end
      end
      OPC_VDOT8: begin
        if (f7 == 7'd0 && f3 == 3'd0) begin
          d.instr_class = CLS_VDOT8;
          d.exec_unit = UNIT_MUL;
        end
      end
      OPC_TLOOKUP: begin
        d.instr_class = CLS_TLOOKUP;
        d.exec_unit = UNIT_TABLE;
        d.immediate = imm_i;
      end
      default: ;
    endcase

    // Register usage follows from the class alone.
    case (d.instr_class)
      CLS_ALU_R, CLS_MUL, CLS_DIV: begin
        d.writes_dest = 1'b1;
        d.source_count = 2'd2;
      end
      CLS_ALU_I, CLS_JALR, CLS_LOAD, CLS_TLOOKUP: begin
        d.writes_dest = 1'b1;
        d.source_count = 2'd1;
      end
      CLS_LUI, CLS_AUIPC, CLS_JAL, CLS_CSR: d.writes_dest = 1'b1;
      CLS_BRANCH, CLS_STORE: d.source_count = 2'd2;
      CLS_VDOT8: begin
        d.writes_dest = 1'b1;
        d.reads_dest = 1'b1;
        d.source_count = 2'd3;
      end
      default: ;
    endcase
    return d;
  endfunction

  // Random instruction, mostly well formed with random content, some pure noise.
  function automatic logic [31:0] random_instruction(input csr_map_t ids);
    logic [31:0] w;
    int pick;
    w = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 12) return w;
    case ($urandom_range(0, 12))
      0:       w[6:0] = OPC_ALU_R;
      1:       w[6:0] = OPC_ALU_I;
      2:       w[6:0] = OPC_LUI;
      3:       w[6:0] = OPC_AUIPC;
      4:       w[6:0] = OPC_JAL;
      5:       w[6:0] = OPC_JALR;
      6:       w[6:0] = OPC_BRANCH;
      7:       w[6:0] = OPC_LOAD;
      8:       w[6:0] = OPC_STORE;
      9:       w[6:0] = OPC_FENCE;
      10:      w[6:0] = OPC_SYSTEM;
      11:      w[6:0] = OPC_VDOT8;
      default: w[6:0] = OPC_TLOOKUP;
    endcase

    // Steer the fields that gate validity toward the accepted values.
    case (w[6:0])
      OPC_ALU_R: begin
        case ($urandom_range(0, 3))
          0:       w[31:25] = F7_BASE;
          1:       w[31:25] = F7_ALT;
          2:       w[31:25] = F7_MD;
          default: ;
        endcase
      end
      OPC_ALU_I: begin
        if (w[14:12] == F3_SLL || w[14:12] == F3_SRL) begin
          case ($urandom_range(0, 2))
            0:       w[31:25] = F7_BASE;
            1:       w[31:25] = F7_ALT;
            default: ;
          endcase
        end
      end
      OPC_JALR: if ($urandom_range(0, 3) != 0) w[14:12] = 3'd0;
      OPC_SYSTEM: begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          w[14:12] = F3_PRIV;
          case ($urandom_range(0, 2))
            0:       w[31:20] = SYS_ECALL;
            1:       w[31:20] = SYS_EBREAK;
            default: ;
          endcase
        end else if (pick < 9) begin
          w[14:12] = F3_CSRRS;
          if ($urandom_range(0, 4) != 0) w[19:15] = 5'd0;
          case ($urandom_range(0, 3))
            0:       w[31:20] = ids.warp_id;
            1:       w[31:20] = ids.lane_id;
            2:       w[31:20] = ids.warp_count;
            default: ;
          endcase
        end
      end
      OPC_VDOT8: begin
        if ($urandom_range(0, 3) != 0) begin
          w[31:25] = 7'd0;
          w[14:12] = 3'd0;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] word,
                             input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d word %h %s: got %h, expected %h",
                                result_beats, word, name, got, want));
  endtask

  // Present one instruction beat, with a random gap first, and record its decode.
  task automatic send_instruction(input logic [31:0] word, input decode_t want);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    instruction_word_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_decodes.push_back('{word, want});
  endtask

  // Stop sending and wait until every decode has come back.
  task automatic finish_burst();
    in_valid_i <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      w = random_instruction(csr_ids);
      send_instruction(w, predict_decode(w, csr_ids));
    end
    finish_burst();
  endtask

  task automatic write_csr_id(input logic [1:0] idx, input logic [11:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_WARP_ID:    csr_ids.warp_id = value;
      CFG_LANE_ID:    csr_ids.lane_id = value;
      CFG_WARP_COUNT: csr_ids.warp_count = value;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_ids(input logic [11:0] warp, input logic [11:0] lane,
                               input logic [11:0] count);
    write_csr_id(CFG_WARP_ID, warp);
    write_csr_id(CFG_LANE_ID, lane);
    write_csr_id(CFG_WARP_COUNT, count);
  endtask

  // Receiver stalls at random while gaps are enabled.
  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(0, 99) < 33);
  end

  // Compare every accepted result beat with the oldest pending decode.
  always @(posedge clk_i) begin
    pending_decode_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with no instruction pending",
                                  result_beats));
      end else begin
        head = pending_decodes.pop_front();
        check_field("instr_class", head.word, 32'(instr_class_o),
                    32'(head.want.instr_class));
        check_field("exec_unit", head.word, 32'(exec_unit_o),
                    32'(head.want.exec_unit));
        check_field("sub_op", head.word, 32'(sub_op_o), 32'(head.want.sub_op));
        check_field("dest_reg", head.word, 32'(dest_reg_o), 32'(head.want.dest_reg));
        check_field("src1_reg", head.word, 32'(src1_reg_o), 32'(head.want.src1_reg));
        check_field("src2_reg", head.word, 32'(src2_reg_o), 32'(head.want.src2_reg));
        check_field("writes_dest", head.word, 32'(writes_dest_o),
                    32'(head.want.writes_dest));
        check_field("reads_dest", head.word, 32'(reads_dest_o),
                    32'(head.want.reads_dest));
        check_field("source_count", head.word, 32'(source_count_o),
                    32'(head.want.source_count));
        check_field("immediate", head.word, immediate_o, head.want.immediate);
        check_field("csr_number", head.word, 32'(csr_number_o),
                    32'(head.want.csr_number));
      end
      result_beats++;
    end
  end

  // Main sequence: directed table, then random phases under several CSR maps.
  initial begin
    csr_ids = '{WARP_ID_CSR_RST, LANE_ID_CSR_RST, WARP_COUNT_CSR_RST};

    // Rows with a typed-in decode: all-zero and all-one words, largest LUI,
    // identity read after reset, environment calls and a bad funct7.
    directed_rows.push_back('{32'h0000_0000, 1'b1,
      '{CLS_INVALID, UNIT_ALU, 4'd0, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 2'd0, 32'd0, 12'd0}});
    directed_rows.push_back('{32'hFFFF_FFFF, 1'b1,
      '{CLS_INVALID, UNIT_ALU, 4'd0, 5'd31, 5'd31, 5'd31, 1'b0, 1'b0, 2'd0, 32'd0, 12'd0}});
    directed_rows.push_back('{32'hFFFF_FFB7, 1'b1,
      '{CLS_LUI, UNIT_ALU, 4'd0, 5'd31, 5'd31, 5'd31, 1'b1, 1'b0, 2'd0,
        32'hFFFF_F000, 12'd0}});
    directed_rows.push_back('{32'hC200_22F3, 1'b1,
      '{CLS_CSR, UNIT_ALU, 4'd0, 5'd5, 5'd0, 5'd0, 1'b1, 1'b0, 2'd0, 32'd0, 12'd3104}});
    directed_rows.push_back('{32'h0000_0073, 1'b1,
      '{CLS_ECALL, UNIT_SYSTEM, 4'd0, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 2'd0, 32'd0, 12'd0}});
    directed_rows.push_back('{32'h0010_0073, 1'b1,
      '{CLS_EBREAK, UNIT_SYSTEM, 4'd0, 5'd0, 5'd0, 5'd1, 1'b0, 1'b0, 2'd0, 32'd0, 12'd0}});
    directed_rows.push_back('{enc_r(F7_ALT, 5'd3, 5'd2, F3_SLL, 5'd1, OPC_ALU_R), 1'b1,
      '{CLS_INVALID, UNIT_ALU, 4'd0, 5'd1, 5'd2, 5'd3, 1'b0, 1'b0, 2'd0, 32'd0, 12'd0}});

    // Rows checked against the predictor.
    directed_rows.push_back('{enc_r(F7_BASE, 5'd31, 5'd0, F3_ADD, 5'd31, OPC_ALU_R),
                              1'b0, '0});
    directed_rows.push_back('{enc_r(F7_ALT, 5'd7, 5'd6, F3_SRL, 5'd5, OPC_ALU_R), 1'b0, '0});
    directed_rows.push_back('{enc_r(F7_MD, 5'd4, 5'd5, 3'd7, 5'd6, OPC_ALU_R), 1'b0, '0});
    directed_rows.push_back('{enc_i(12'h800, 5'd1, F3_ADD, 5'd2, OPC_ALU_I), 1'b0, '0});
    directed_rows.push_back('{enc_i({F7_MD, 5'd3}, 5'd1, F3_SLL, 5'd2, OPC_ALU_I), 1'b0, '0});
    directed_rows.push_back('{enc_i({F7_ALT, 5'd31}, 5'd1, F3_SRL, 5'd2, OPC_ALU_I),
                              1'b0, '0});
    directed_rows.push_back('{enc_i(12'hFFF, 5'd3, 3'd1, 5'd4, OPC_JALR), 1'b0, '0});
    directed_rows.push_back('{32'hFFFF_F0EF, 1'b0, '0});
    directed_rows.push_back('{enc_r(7'h7F, 5'd9, 5'd8, 3'd7, 5'h1F, OPC_BRANCH), 1'b0, '0});
    directed_rows.push_back('{enc_i(12'h7FF, 5'd10, 3'd5, 5'd11, OPC_LOAD), 1'b0, '0});
    directed_rows.push_back('{enc_i(12'h001, 5'd10, 3'd3, 5'd11, OPC_LOAD), 1'b0, '0});
    directed_rows.push_back('{enc_r(7'h7F, 5'd12, 5'd13, 3'd2, 5'h1F, OPC_STORE), 1'b0, '0});
    directed_rows.push_back('{32'hFFFF_FF8F, 1'b0, '0});
    directed_rows.push_back('{enc_i(12'h002, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM), 1'b0, '0});
    directed_rows.push_back('{enc_i(LANE_ID_CSR_RST, 5'd3, F3_CSRRS, 5'd7, OPC_SYSTEM),
                              1'b0, '0});
    directed_rows.push_back('{enc_i(WARP_COUNT_CSR_RST, 5'd0, F3_CSRRS, 5'd7, OPC_SYSTEM),
                              1'b0, '0});
    directed_rows.push_back('{enc_r(F7_BASE, 5'd14, 5'd15, 3'd0, 5'd16, OPC_VDOT8), 1'b0, '0});
    directed_rows.push_back('{enc_r(7'h40, 5'd14, 5'd15, 3'd0, 5'd16, OPC_VDOT8), 1'b0, '0});
    directed_rows.push_back('{enc_i(12'h800, 5'd17, 3'd7, 5'd18, OPC_TLOOKUP), 1'b0, '0});
    directed_rows.push_back('{{20'h80000, 5'd19, OPC_AUIPC}, 1'b0, '0});

    // Hold reset, then release it.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_instruction(directed_rows[i].word,
                       directed_rows[i].fixed ? directed_rows[i].want
                                              : predict_decode(directed_rows[i].word,
                                                               csr_ids));
    end
    finish_burst();

    // Reset CSR map.
    run_random(300);

    // Lowest CSR numbers.
    write_all_ids(12'h000, 12'h000, 12'h000);
    run_random(300);

    // Highest CSR numbers.
    write_all_ids(12'hFFF, 12'hFFF, 12'hFFF);
    run_random(300);

    // Random map plus a write to the unused index; no idling on either side.
    write_all_ids(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)));
    write_csr_id(CFG_UNUSED, 12'($urandom_range(0, 4095)));
    gaps_on = 1'b0;
    run_random(300);
    gaps_on = 1'b1;

    // All three identities on one CSR number.
    begin
      logic [11:0] shared_csr;
      shared_csr = 12'($urandom_range(0, 4095));
      write_all_ids(shared_csr, shared_csr, shared_csr);
    end
    run_random(300);

    // Fresh random map.
    write_all_ids(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)));
    run_random(450);

    repeat (6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
